@@ hdl/qej_pkg.sv @@
// Package for the quad element Jacobian block: widths, payload structures,
// state machine types and the 32-bit saturation function.
// No dependencies; compile first.
`default_nettype none

package qej_pkg;

    localparam int NODES_DEF = 4;

    localparam int PT_W    = 4;   // integration point number
    localparam int NODE_W  = 3;   // node number on the output
    localparam int C_W     = 32;  // Q16.16 coordinates and results
    localparam int D_W     = 16;  // Q2.14 shape derivatives
    localparam int ACC_W   = 48;  // Jacobian sums
    localparam int PROD_W  = 64;  // shared multiplier product
    localparam int FRAC_SH = 14;  // product to sum alignment
    localparam int DET_SH  = 16;  // determinant scaling
    localparam int NUM_W   = 51;  // quotient numerator
    localparam int DEN_W   = 48;  // determinant
    localparam int QMAG_W  = 33;  // quotient magnitude bits before saturation
    localparam int STEP_W  = $clog2(QMAG_W);
    localparam int NSUM    = 4;

    // Jacobian entry selects, also the order of the sums.
    localparam logic [1:0] SEL_XK = 2'd0;
    localparam logic [1:0] SEL_YK = 2'd1;
    localparam logic [1:0] SEL_XE = 2'd2;
    localparam logic [1:0] SEL_YE = 2'd3;

    typedef struct packed {
        logic [PT_W-1:0]       point_index;
        logic signed [C_W-1:0] coord_x;
        logic signed [C_W-1:0] coord_y;
        logic signed [D_W-1:0] dn_dksi;
        logic signed [D_W-1:0] dn_deta;
    } t_in_item;

    typedef struct packed {
        logic [PT_W-1:0]       point_out;
        logic [NODE_W-1:0]     node_out;
        logic signed [C_W-1:0] dn_dx;
        logic signed [C_W-1:0] dn_dy;
        logic signed [C_W-1:0] jac_xk;
        logic signed [C_W-1:0] jac_yk;
        logic signed [C_W-1:0] jac_xe;
        logic signed [C_W-1:0] jac_ye;
        logic signed [C_W-1:0] det_value;
        logic                  singular;
        logic                  last_node;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SAT,
        S_DET1,
        S_DET2,
        S_DET3,
        S_DET4,
        S_DET5,
        S_N1,
        S_N2,
        S_N3,
        S_N4,
        S_N5,
        S_N6,
        S_WX,
        S_DY,
        S_WY,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIN
    } t_div_state;

    // Saturate a 48-bit signed value to 32 bits.
    function automatic logic signed [C_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [C_W-1:0] res;
        if (v[ACC_W-1:C_W-1] == {(ACC_W-C_W+1){v[ACC_W-1]}}) begin
            res = v[C_W-1:0];
        end else begin
            res = {v[ACC_W-1], {(C_W-1){~v[ACC_W-1]}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/qej_chan_if.sv @@
// Valid/ready channel carrying one payload structure per transfer.
// The payload type is given by the instantiating level (see qej_pkg).
`default_nettype none

interface qej_chan_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ hdl/quad_element_jacobian.sv @@
// Top level of the quad element Jacobian block: sequencer and datapath around
// the shared multiplier and the bit-serial divider.
// Depends on qej_pkg, qej_chan_if, qej_mul and qej_div.
//
//  Channel  Direction  Transfer moves
//  -------  ---------  -------------------------------------------------------
//  i_in     in         one node: point number, x, y, dN/dksi, dN/deta
//  o_out    out        one node result: dN/dx, dN/dy, Jacobian, determinant
//
// A node other than the last takes the transfer and four
// multiply/accumulate pairs through the shared multiplier.
// The last node adds saturation and the determinant; each result then spends
// almost all of its time in two 33-step divisions in the
// bit-serial divider; a singular element skips the divisions.
// The input is not ready from a transfer until the run is done or the node
// stored; a stalled output simply holds the sequencer in its output state.
// Reset is synchronous and active low; it clears the sums, the node count and
// the sequencers.
`default_nettype none

module quad_element_jacobian #(
    parameter int NODES = qej_pkg::NODES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qej_chan_if.sink   i_in,
    qej_chan_if.source o_out
);
    import qej_pkg::*;

    localparam int CNT_W = $clog2(NODES);

    t_state r_state, n_state;

    // Control state
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_k;
    logic [1:0]               r_sel;
    logic signed [ACC_W-1:0]  r_sum [NSUM];
    logic [PT_W-1:0]          r_point;

    // Datapath registers
    logic signed [C_W-1:0]    r_x;
    logic signed [C_W-1:0]    r_y;
    logic signed [D_W-1:0]    r_dk;
    logic signed [D_W-1:0]    r_de;
    logic [2*D_W-1:0]         r_deriv [NODES];
    logic signed [C_W-1:0]    r_j [NSUM];
    logic signed [PROD_W-1:0] r_p1;
    logic signed [DEN_W-1:0]  r_det;
    logic signed [C_W-1:0]    r_dsat;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [NUM_W-1:0]  r_num;
    logic signed [C_W-1:0]    r_gx;
    logic signed [C_W-1:0]    r_gy;

    logic                     w_in_xfer;
    logic                     w_out_xfer;
    logic                     w_last_k;
    logic                     w_singular;
    logic signed [C_W-1:0]    w_dk_ext;
    logic signed [C_W-1:0]    w_de_ext;
    logic signed [C_W-1:0]    w_sk_ext;
    logic signed [C_W-1:0]    w_se_ext;
    logic signed [C_W-1:0]    w_mul_a;
    logic signed [C_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [NUM_W-1:0]  w_diff;
    logic signed [PROD_W-1:0] w_dadj;
    logic                     w_div_start;
    logic                     w_div_done;
    logic signed [C_W-1:0]    w_div_quot;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign w_last_k   = (r_k == CNT_W'(NODES-1));
    assign w_singular = (r_det == '0);

    // Sign-extended derivatives: the current input, and the stored pair of
    // the node whose result is being formed.
    assign w_dk_ext = {{(C_W-D_W){r_dk[D_W-1]}}, r_dk};
    assign w_de_ext = {{(C_W-D_W){r_de[D_W-1]}}, r_de};
    assign w_sk_ext = {{(C_W-D_W){r_deriv[r_k][2*D_W-1]}}, r_deriv[r_k][2*D_W-1:D_W]};
    assign w_se_ext = {{(C_W-D_W){r_deriv[r_k][D_W-1]}}, r_deriv[r_k][D_W-1:0]};

    // Numerator of a quotient: four times the difference of two products.
    // Both products fit 48 bits, so the low bits carry the exact difference.
    assign w_diff = r_pa[NUM_W-1:0] - w_prod[NUM_W-1:0];

    // Determinant truncated toward zero: negative values are biased up by
    // one less than the divisor before the arithmetic shift.
    assign w_dadj = r_p1 + {{(PROD_W-DET_SH){1'b0}}, {DET_SH{r_p1[PROD_W-1]}}};

    qej_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    qej_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, handshakes and the multiplier operands.
    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
                case (r_sel)
                    SEL_XK: begin
                        w_mul_a = w_dk_ext;
                        w_mul_b = r_x;
                    end
                    SEL_YK: begin
                        w_mul_a = w_dk_ext;
                        w_mul_b = r_y;
                    end
                    SEL_XE: begin
                        w_mul_a = w_de_ext;
                        w_mul_b = r_x;
                    end
                    default: begin
                        w_mul_a = w_de_ext;
                        w_mul_b = r_y;
                    end
                endcase
            end
            S_ADD: begin
                if (r_sel != SEL_YE) begin
                    n_state = S_MUL;
                end else if (r_cnt == CNT_W'(NODES-1)) begin
                    n_state = S_SAT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SAT: n_state = S_DET1;
            S_DET1: begin
                w_mul_a = r_j[SEL_XK];
                w_mul_b = r_j[SEL_YE];
                n_state = S_DET2;
            end
            S_DET2: begin
                w_mul_a = r_j[SEL_YK];
                w_mul_b = r_j[SEL_XE];
                n_state = S_DET3;
            end
            S_DET3: n_state = S_DET4;
            S_DET4: n_state = S_DET5;
            S_DET5: n_state = S_N1;
            S_N1: begin
                w_mul_a = r_j[SEL_YE];
                w_mul_b = w_sk_ext;
                n_state = w_singular ? S_OUT : S_N2;
            end
            S_N2: begin
                w_mul_a = r_j[SEL_YK];
                w_mul_b = w_se_ext;
                n_state = S_N3;
            end
            S_N3: n_state = S_N4;
            S_N4: begin
                w_div_start = 1'b1;
                w_mul_a     = r_j[SEL_XK];
                w_mul_b     = w_se_ext;
                n_state     = S_N5;
            end
            S_N5: begin
                w_mul_a = r_j[SEL_XE];
                w_mul_b = w_sk_ext;
                n_state = S_N6;
            end
            S_N6: n_state = S_WX;
            S_WX: begin
                if (w_div_done) begin
                    n_state = S_DY;
                end
            end
            S_DY: begin
                w_div_start = 1'b1;
                n_state     = S_WY;
            end
            S_WY: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = w_last_k ? S_IDLE : S_N1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers: node count, result index, sums and the point number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_k     <= '0;
            r_sel   <= SEL_XK;
            r_point <= '0;
            for (int i = 0; i < NSUM; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (w_in_xfer) begin
                r_sel <= SEL_XK;
                if (r_cnt == '0) begin
                    r_point <= i_in.payload.point_index;
                end
            end
            if (r_state == S_ADD) begin
                // Floor shift of the product by 14, wrapped to 48 bits.
                r_sum[r_sel] <= r_sum[r_sel] + w_prod[ACC_W+FRAC_SH-1:FRAC_SH];
                r_sel        <= r_sel + 1'b1;
                if (r_sel == SEL_YE && r_cnt != CNT_W'(NODES-1)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == S_SAT) begin
                r_k <= '0;
            end
            if (w_out_xfer) begin
                if (w_last_k) begin
                    r_cnt <= '0;
                    for (int i = 0; i < NSUM; i++) begin
                        r_sum[i] <= '0;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_x            <= i_in.payload.coord_x;
            r_y            <= i_in.payload.coord_y;
            r_dk           <= i_in.payload.dn_dksi;
            r_de           <= i_in.payload.dn_deta;
            r_deriv[r_cnt] <= {i_in.payload.dn_dksi, i_in.payload.dn_deta};
        end
        case (r_state)
            S_SAT: begin
                for (int i = 0; i < NSUM; i++) begin
                    r_j[i] <= sat32(r_sum[i]);
                end
            end
            S_DET2: r_p1 <= w_prod;
            S_DET3: r_p1 <= r_p1 - w_prod;
            S_DET4: r_det <= w_dadj[PROD_W-1:DET_SH];
            S_DET5: r_dsat <= sat32(r_det);
            S_N1: begin
                // A zero determinant leaves both derivatives at zero.
                if (w_singular) begin
                    r_gx <= '0;
                    r_gy <= '0;
                end
            end
            S_N2, S_N5: r_pa <= w_prod;
            S_N3, S_N6: r_num <= {w_diff[NUM_W-3:0], 2'b00};
            S_WX: begin
                if (w_div_done) begin
                    r_gx <= w_div_quot;
                end
            end
            S_WY: begin
                if (w_div_done) begin
                    r_gy <= w_div_quot;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_out.payload.point_out = r_point;
        o_out.payload.node_out  = NODE_W'(r_k);
        o_out.payload.dn_dx     = r_gx;
        o_out.payload.dn_dy     = r_gy;
        o_out.payload.jac_xk    = r_j[SEL_XK];
        o_out.payload.jac_yk    = r_j[SEL_YK];
        o_out.payload.jac_xe    = r_j[SEL_XE];
        o_out.payload.jac_ye    = r_j[SEL_YE];
        o_out.payload.det_value = r_dsat;
        o_out.payload.singular  = w_singular;
        o_out.payload.last_node = w_last_k;
    end

    // The block never takes a node while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is offered");

    // After a node transfer the block is busy with its products.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_in.ready)
        else $error("input ready straight after a node transfer");

    // The final result of a run leaves the block cleared and ready.
    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && o_out.payload.last_node |=>
            i_in.ready && r_cnt == '0 && r_sum[0] == '0 && r_sum[3] == '0)
        else $error("run did not clear after its last result");

    // A singular element reports zero derivatives.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.singular |->
            o_out.payload.dn_dx == '0 && o_out.payload.dn_dy == '0)
        else $error("non-zero derivative on a singular element");

    // A division finishes only while the sequencer waits for it.
    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_WX || r_state == S_WY))
        else $error("division finished outside a wait state");

endmodule

`default_nettype wire

@@ hdl/qej_mul.sv @@
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// Depends on qej_pkg for widths.
`default_nettype none

module qej_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [qej_pkg::C_W-1:0]     i_a,
    input  wire logic signed [qej_pkg::C_W-1:0]     i_b,
    output      logic signed [qej_pkg::PROD_W-1:0]  o_prod
);
    import qej_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Both operands are signed, so they are sign extended to the product width.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hdl/qej_div.sv @@
// Bit-serial signed divider: one quotient bit per cycle, truncation toward
// zero, result saturated to 32 bits. Depends on qej_pkg.
`default_nettype none

module qej_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [qej_pkg::NUM_W-1:0]  i_num,
    input  wire logic signed [qej_pkg::DEN_W-1:0]  i_den,
    output      logic                              o_done,
    output      logic signed [qej_pkg::C_W-1:0]    o_quot
);
    import qej_pkg::*;

    t_div_state r_state, n_state;

    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [QMAG_W-1:0] r_quo;
    logic              r_neg;
    logic              r_ovf;
    logic [STEP_W-1:0] r_step;

    logic [NUM_W-1:0]  w_num_mag;
    logic [DEN_W-1:0]  w_den_mag;
    logic              w_ovf;
    logic [DEN_W+1:0]  w_trial;
    logic              w_fits;
    logic              w_pos_big;
    logic              w_neg_big;

    assign w_num_mag = i_num[NUM_W-1] ? -i_num : i_num;
    assign w_den_mag = i_den[DEN_W-1] ? -i_den : i_den;
    // The quotient needs more than QMAG_W bits exactly when the numerator's
    // upper part already reaches the divisor.
    assign w_ovf     = DEN_W'(w_num_mag[NUM_W-1:QMAG_W]) >= w_den_mag;

    assign w_trial = {1'b0, r_rem, r_quo[QMAG_W-1]} - {2'b00, r_den};
    assign w_fits  = !w_trial[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_step == STEP_W'(QMAG_W-1)) begin
                    n_state = DIV_FIN;
                end
            end
            DIV_FIN: begin
                o_done  = 1'b1;
                n_state = DIV_IDLE;
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == DIV_IDLE && i_start) begin
            r_rem  <= DEN_W'(w_num_mag[NUM_W-1:QMAG_W]);
            r_quo  <= w_num_mag[QMAG_W-1:0];
            r_den  <= w_den_mag;
            r_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_ovf  <= w_ovf;
            r_step <= '0;
        end else if (r_state == DIV_RUN) begin
            r_rem  <= w_fits ? w_trial[DEN_W-1:0] : {r_rem[DEN_W-2:0], r_quo[QMAG_W-1]};
            r_quo  <= {r_quo[QMAG_W-2:0], w_fits};
            r_step <= r_step + 1'b1;
        end
    end

    assign w_pos_big = r_ovf || (r_quo[QMAG_W-1:C_W-1] != '0);
    assign w_neg_big = r_ovf || r_quo[QMAG_W-1] || (r_quo[C_W-1] && (r_quo[C_W-2:0] != '0));

    always_comb begin
        if (r_neg) begin
            o_quot = w_neg_big ? {1'b1, {(C_W-1){1'b0}}} : -r_quo[C_W-1:0];
        end else begin
            o_quot = w_pos_big ? {1'b0, {(C_W-1){1'b1}}} : r_quo[C_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ dv/quad_element_jacobian_checker.sv @@
// Result checker for the quad element Jacobian block: predicts the node results
// of every element from the accepted node transfers and compares them field by field.
// Depends on qej_pkg; instantiated by quad_element_jacobian_test.
`timescale 1ns / 1ps

module quad_element_jacobian_checker #(
    parameter int NODES = qej_pkg::NODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  qej_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  qej_pkg::t_out_item i_out_item,
    output int                 o_failures,
    output int                 o_pending
);
    import qej_pkg::*;

    // Jacobian sums in Q32.16, wrapping at 48 bits.
    logic signed [ACC_W-1:0] sum_xk, sum_yk, sum_xe, sum_ye;
    logic signed [D_W-1:0]   dksi_store [NODES];
    logic signed [D_W-1:0]   deta_store [NODES];
    int                      nodes_taken;
    logic [PT_W-1:0]         point_held;
    t_out_item               due_results [$];
    t_out_item               oldest;

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    function automatic logic signed [C_W-1:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[C_W-1:0];
    endfunction

    // Takes one node; on the last node of an element queues one result per node.
    task automatic absorb_node(input t_in_item it);
        longint    cx, cy, dk, de;
        longint    jxk, jyk, jxe, jye, det_full, det, sk, se, gx, gy;
        int        slot;
        t_out_item res;
        cx   = it.coord_x;
        cy   = it.coord_y;
        dk   = it.dn_dksi;
        de   = it.dn_deta;
        slot = nodes_taken;
        if (slot == 0) begin
            point_held = it.point_index;
        end
        if (slot >= NODES) begin
            slot = NODES - 1;
        end
        dksi_store[slot] = it.dn_dksi;
        deta_store[slot] = it.dn_deta;
        // Products are Q18.30; the arithmetic shift rounds toward minus infinity.
        sum_xk = sum_xk + ((dk * cx) >>> FRAC_SH);
        sum_yk = sum_yk + ((dk * cy) >>> FRAC_SH);
        sum_xe = sum_xe + ((de * cx) >>> FRAC_SH);
        sum_ye = sum_ye + ((de * cy) >>> FRAC_SH);
        if (slot + 1 < NODES) begin
            nodes_taken = slot + 1;
            return;
        end
        jxk      = clamp_q16(sum_xk);
        jyk      = clamp_q16(sum_yk);
        jxe      = clamp_q16(sum_xe);
        jye      = clamp_q16(sum_ye);
        det_full = jxk * jye - jyk * jxe;
        det      = det_full / 65536;
        for (int k = 0; k < NODES; k++) begin
            sk = dksi_store[k];
            se = deta_store[k];
            gx = 0;
            gy = 0;
            if (det != 0) begin
                gx = clamp_q16(((jye * sk - jyk * se) * 4) / det);
                gy = clamp_q16(((jxk * se - jxe * sk) * 4) / det);
            end
            res.point_out = point_held;
            res.node_out  = NODE_W'(k);
            res.dn_dx     = gx[C_W-1:0];
            res.dn_dy     = gy[C_W-1:0];
            res.jac_xk    = jxk[C_W-1:0];
            res.jac_yk    = jyk[C_W-1:0];
            res.jac_xe    = jxe[C_W-1:0];
            res.jac_ye    = jye[C_W-1:0];
            res.det_value = clamp_q16(det);
            res.singular  = (det == 0);
            res.last_node = (k == NODES - 1);
            due_results.push_back(res);
        end
        sum_xk      = '0;
        sum_yk      = '0;
        sum_xe      = '0;
        sum_ye      = '0;
        nodes_taken = 0;
    endtask

    task automatic check_field(input string name, input logic [C_W-1:0] want,
                               input logic [C_W-1:0] got);
        if (want !== got) begin
            o_failures++;
            if (o_failures <= 10) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sum_xk      = '0;
            sum_yk      = '0;
            sum_xe      = '0;
            sum_ye      = '0;
            nodes_taken = 0;
            point_held  = '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                absorb_node(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10) begin
                        $display("%0t: result transfer with none expected: %p", $time,
                                 i_out_item);
                    end
                end else begin
                    oldest = due_results.pop_front();
                    check_field("point_out", oldest.point_out, i_out_item.point_out);
                    check_field("node_out",  oldest.node_out,  i_out_item.node_out);
                    check_field("dn_dx",     oldest.dn_dx,     i_out_item.dn_dx);
                    check_field("dn_dy",     oldest.dn_dy,     i_out_item.dn_dy);
                    check_field("jac_xk",    oldest.jac_xk,    i_out_item.jac_xk);
                    check_field("jac_yk",    oldest.jac_yk,    i_out_item.jac_yk);
                    check_field("jac_xe",    oldest.jac_xe,    i_out_item.jac_xe);
                    check_field("jac_ye",    oldest.jac_ye,    i_out_item.jac_ye);
                    check_field("det_value", oldest.det_value, i_out_item.det_value);
                    check_field("singular",  oldest.singular,  i_out_item.singular);
                    check_field("last_node", oldest.last_node, i_out_item.last_node);
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

@@ dv/quad_element_jacobian_test.sv @@
// Top level of the quad element Jacobian testbench: clock, reset, node stimulus,
// result back-pressure, watchdog and verdict.
// Depends on qej_pkg, qej_chan_if, quad_element_jacobian and its checker.
`timescale 1ns / 1ps

module quad_element_jacobian_test;

    import qej_pkg::*;

    localparam int NODE_COUNT = NODES_DEF;
    // The longest honest silence on both channels is the last node's set-up plus
    // one division pair and a receiver stall.
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RUNS_PER_PHASE [3] = '{16, 16, 17};
    localparam int SEND_IDLE [3]      = '{26, 60, 0};
    localparam int TAKE_IDLE [3]      = '{60, 26, 0};

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     rx_ready = 1'b0;
    int       in_idle_pct  = 26;
    int       out_idle_pct = 60;
    int       quiet_cycles = 0;
    int       failures;
    int       pending;
    t_in_item elem [NODE_COUNT];

    qej_chan_if #(.t_payload(t_in_item))  node_ch ();
    qej_chan_if #(.t_payload(t_out_item)) result_ch ();

    assign result_ch.ready = rx_ready;

    quad_element_jacobian #(
        .NODES (NODE_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (node_ch),
        .o_out   (result_ch)
    );

    quad_element_jacobian_checker #(
        .NODES (NODE_COUNT)
    ) result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (node_ch.valid),
        .i_in_ready  (node_ch.ready),
        .i_in_item   (node_ch.payload),
        .i_out_valid (result_ch.valid),
        .i_out_ready (result_ch.ready),
        .i_out_item  (result_ch.payload),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // The receiver decides afresh at every falling edge whether it will take a
    // result at the next rising edge.
    always @(negedge i_clk) begin
        rx_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Watchdog: any transfer on either channel restarts the count of silent cycles.
    always @(posedge i_clk) begin
        if ((node_ch.valid && node_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_node(input int k, input logic [PT_W-1:0] pt,
                            input logic signed [C_W-1:0] x, input logic signed [C_W-1:0] y,
                            input logic signed [D_W-1:0] dk, input logic signed [D_W-1:0] de);
        elem[k].point_index = pt;
        elem[k].coord_x     = x;
        elem[k].coord_y     = y;
        elem[k].dn_dksi     = dk;
        elem[k].dn_deta     = de;
    endtask

    // Offers each node of the element in turn. Called and left at a falling
    // edge; valid stays high between back-to-back transfers and is only lowered
    // for an idle cycle of the sender.
    task automatic send_element();
        for (int k = 0; k < NODE_COUNT; k++) begin
            while ($urandom_range(99) < in_idle_pct) begin
                node_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            node_ch.valid   <= 1'b1;
            node_ch.payload <= elem[k];
            @(posedge i_clk);
            while (!node_ch.ready) begin
                @(posedge i_clk);
            end
            @(negedge i_clk);
        end
    endtask

    // Holds the sender back until every predicted result has been transferred.
    task automatic drain_results();
        node_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // Half of the elements are genuine bilinear quads at a random integration point:
    // moderately distorted, of any size and either orientation. The rest are
    // raw random fields (which mostly saturate), tiny elements with large
    // derivatives (small determinants, saturated quotients) and elements with
    // every node on the line y = x, which are exactly singular.
    task automatic build_random_element();
        int kind, ksi, eta, scale, cx, cy, mirror, sx, sy, x, y, dk, de;
        kind   = $urandom_range(9);
        ksi    = int'($urandom_range(32768)) - 16384;
        eta    = int'($urandom_range(32768)) - 16384;
        scale  = 1 << $urandom_range(8, 24);
        cx     = int'($urandom_range(1 << 29)) - (1 << 28);
        cy     = int'($urandom_range(1 << 29)) - (1 << 28);
        mirror = $urandom_range(1) ? 1 : -1;
        for (int k = 0; k < NODE_COUNT; k++) begin
            sx = (k == 1 || k == 2) ? 1 : -1;
            sy = (k >= 2) ? 1 : -1;
            if (kind <= 4) begin
                x  = cx + mirror * sx * scale + int'($urandom_range(scale / 2)) - scale / 4;
                y  = cy + sy * scale + int'($urandom_range(scale / 2)) - scale / 4;
                dk = sx * (16384 + sy * eta) / 4;
                de = sy * (16384 + sx * ksi) / 4;
            end else if (kind <= 6) begin
                x  = $urandom;
                y  = $urandom;
                dk = $urandom;
                de = $urandom;
            end else if (kind <= 8) begin
                x  = int'($urandom_range(1023)) - 512;
                y  = int'($urandom_range(1023)) - 512;
                dk = $urandom;
                de = $urandom;
            end else begin
                x  = $urandom;
                y  = x;
                dk = $urandom;
                de = $urandom;
            end
            set_node(k, PT_W'($urandom_range(15)), x, y, dk[D_W-1:0], de[D_W-1:0]);
        end
    endtask

    initial begin
        node_ch.valid   = 1'b0;
        node_ch.payload = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unit square at the element centre: identity Jacobian, determinant one.
        set_node(0, 4'd0, -32'sd65536, -32'sd65536, -16'sd4096, -16'sd4096);
        set_node(1, 4'd0,  32'sd65536, -32'sd65536,  16'sd4096, -16'sd4096);
        set_node(2, 4'd0,  32'sd65536,  32'sd65536,  16'sd4096,  16'sd4096);
        set_node(3, 4'd0, -32'sd65536,  32'sd65536, -16'sd4096,  16'sd4096);
        send_element();

        // All nodes at the origin: singular. The point number changes on the
        // later nodes and must be ignored there.
        set_node(0, 4'd15, 32'sd0, 32'sd0, 16'sh8000, 16'sh7fff);
        set_node(1, 4'd3,  32'sd0, 32'sd0, 16'sh7fff, 16'sh8000);
        set_node(2, 4'd7,  32'sd0, 32'sd0, 16'sh0001, 16'shffff);
        set_node(3, 4'd9,  32'sd0, 32'sd0, 16'sh0000, 16'sh0000);
        send_element();

        // Extreme coordinates and derivatives: the sums for jac_xk and jac_ye saturate.
        set_node(0, 4'd12, 32'sh7fff_ffff, 32'sh8000_0000, 16'sh7fff, 16'sh8000);
        set_node(1, 4'd1,  32'sh8000_0000, 32'sh7fff_ffff, 16'sh8000, 16'sh7fff);
        set_node(2, 4'd2,  32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff, 16'sh7fff);
        set_node(3, 4'd4,  32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh8000);
        send_element();

        // One unit-derivative node per Jacobian entry: jac_xk = 1 LSB and
        // jac_ye = full scale, so the quotients of the last two nodes saturate.
        set_node(0, 4'd5, 32'sd1, 32'sd0,          16'sd16384, 16'sd0);
        set_node(1, 4'd5, 32'sd0, 32'sh7fff_ffff,  16'sd0,     16'sd16384);
        set_node(2, 4'd5, 32'sd0, 32'sd0,          16'sh8000,  16'sh7fff);
        set_node(3, 4'd5, 32'sd0, 32'sd0,          16'sh7fff,  16'sh8000);
        send_element();

        // Determinant of minus one LSB from the off-diagonal entries alone.
        set_node(0, 4'd10, 32'sd0,   32'sd256, 16'sd16384, 16'sd0);
        set_node(1, 4'd10, 32'sd256, 32'sd0,   16'sd0,     16'sd16384);
        set_node(2, 4'd10, 32'sd0,   32'sd0,   16'sd12345, -16'sd2222);
        set_node(3, 4'd10, 32'sd0,   32'sd0,   16'sh8000,  16'sh8000);
        send_element();

        // Non-zero Jacobian whose determinant truncates to zero: singular.
        set_node(0, 4'd6, 32'sd255, 32'sd0,   16'sd16384, 16'sd0);
        set_node(1, 4'd6, 32'sd0,   32'sd256, 16'sd0,     16'sd16384);
        set_node(2, 4'd6, 32'sd0,   32'sd0,   16'sd3000,  -16'sd7000);
        set_node(3, 4'd6, 32'sd0,   32'sd0,   -16'sd1,    16'sd1);
        send_element();
        drain_results();

        // Random elements in three idling phases, each ending with a drain.
        for (int phase = 0; phase < 3; phase++) begin
            in_idle_pct  = SEND_IDLE[phase];
            out_idle_pct = TAKE_IDLE[phase];
            repeat (RUNS_PER_PHASE[phase]) begin
                build_random_element();
                send_element();
            end
            drain_results();
        end

        // Stay a while longer so that any spurious result still shows up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
